>>> rtl/core/tty_line_discipline_core_defines.svh
// Assertion macros for the tty line discipline core.
// Relies on clk_i and rst_ni being in scope at the point of use.
`ifndef TTY_LINE_DISCIPLINE_CORE_DEFINES_SVH
`define TTY_LINE_DISCIPLINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define TLD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset.
`define TLD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TLD_ASSERT_IMP(name, ante, cons, msg)
`define TLD_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

>>> rtl/core/tld_pkg.sv
// Package for the tty line discipline core: payload structs, codes, sizes.
// No dependencies.
package tld_pkg;

  localparam int BUF_DEPTH = 64;
  localparam int PTR_W     = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  localparam logic [1:0] KIND_ECHO   = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_BLOCK = 2'd1;
  localparam logic [1:0] STAT_ZERO  = 2'd2;
  localparam logic [1:0] STAT_DROP  = 2'd3;

  localparam logic CMD_KEY  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic CFG_ECHO  = 1'b0;
  localparam logic CFG_CANON = 1'b1;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef struct packed {
    logic       command;
    logic [7:0] key_char;
    logic [6:0] read_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_char;
    logic [1:0] status;
    logic [6:0] count;
    logic       last;
  } out_item_t;

  // Ring pointer plus offset; offset never exceeds the depth, so one
  // compare and subtract wraps it.
  function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(BUF_DEPTH)) begin
      sum = sum - (CNT_W+1)'(BUF_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

>>> rtl/core/tty_line_discipline_core.sv
// Top level of the tty line discipline: line store, echo and read sequencer.
// Depends on tld_pkg and tty_line_discipline_core_defines.svh.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i / in_stall_o  in_data_i   (in_item_t)
//   out       output     out_valid_o / out_stall_i out_data_o (out_item_t)
//   cfg       input      cfg_we_i                 cfg_addr_i, cfg_wdata_i
//
// Steps: a keystroke is accepted in idle, then any echo and status results
// are emitted one by one. A canonical read scans bytes up to the line
// end, then returns bytes; a raw read only returns bytes. Each byte passes a
// read state and then a check or output state, set by the single read port
// of the line store and its registered read data. Reset empties the store at
// once (fill level and head pointer cleared); store contents are left as
// they are. Output stall holds the sequencer; the last result of an item may
// wait in the output register while the next item is accepted.
`include "tty_line_discipline_core_defines.svh"

module tty_line_discipline_core
  import tld_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_addr_i,
  input  logic      cfg_wdata_i
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_ECHO     = 8'b0000_0010,
    S_STATUS   = 8'b0000_0100,
    S_SCAN_RD  = 8'b0000_1000,
    S_SCAN_CHK = 8'b0001_0000,
    S_DATA_RD  = 8'b0010_0000,
    S_DATA_OUT = 8'b0100_0000,
    S_UNUSED   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Ring buffer bookkeeping
  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] fill_q, fill_d;

  logic echo_q, canon_q;

  // Per-item working registers
  logic [7:0]       char_q, char_d;
  logic             erase_q, erase_d;
  logic             drop_q, drop_d;
  logic [1:0]       ecnt_q, ecnt_d;
  logic [1:0]       status_q, status_d;
  logic [6:0]       n_q, n_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] take_q, take_d;
  logic [CNT_W-1:0] cons_q, cons_d;

  // Output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;
  logic      can_emit;

  // Line store
  logic [7:0]       mem [BUF_DEPTH];
  logic             mem_we, mem_re;
  logic [PTR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]       rd_data_q;

  logic             accept;
  logic             is_erase;
  logic [CNT_W-1:0] idx_inc;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign can_emit    = !out_valid_q || !out_stall_i;
  assign is_erase    = (in_data_i.key_char == CH_BS) || (in_data_i.key_char == CH_DEL);
  assign idx_inc     = idx_q + CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    fill_d      = fill_q;
    char_d      = char_q;
    erase_d     = erase_q;
    drop_d      = drop_q;
    ecnt_d      = ecnt_q;
    status_d    = status_q;
    n_d         = n_q;
    idx_d       = idx_q;
    take_d      = take_q;
    cons_d      = cons_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = wrap_add(head_q, fill_q);
    mem_raddr   = wrap_add(head_q, idx_q);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          char_d = in_data_i.key_char;
          n_d    = in_data_i.read_count;
          idx_d  = '0;
          ecnt_d = '0;
          unique case (in_data_i.command)
            CMD_KEY: begin
              erase_d = is_erase;
              drop_d  = 1'b0;
              if (is_erase) begin
                // Erase on an empty store is ignored silently
                if (fill_q != '0) begin
                  fill_d = fill_q - CNT_W'(1);
                  if (echo_q) begin
                    state_d = S_ECHO;
                  end
                end
              end else if (fill_q >= CNT_W'(BUF_DEPTH)) begin
                drop_d   = 1'b1;
                status_d = STAT_DROP;
                state_d  = echo_q ? S_ECHO : S_STATUS;
              end else begin
                mem_we = 1'b1;
                fill_d = fill_q + CNT_W'(1);
                if (echo_q) begin
                  state_d = S_ECHO;
                end
              end
            end
            CMD_READ: begin
              if (canon_q) begin
                state_d = S_SCAN_RD;
              end else if (in_data_i.read_count == '0) begin
                status_d = STAT_ZERO;
                state_d  = S_STATUS;
              end else if (in_data_i.read_count > 7'(fill_q)) begin
                status_d = STAT_BLOCK;
                state_d  = S_STATUS;
              end else begin
                take_d  = CNT_W'(in_data_i.read_count);
                cons_d  = CNT_W'(in_data_i.read_count);
                state_d = S_DATA_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_ECHO: begin
        if (can_emit) begin
          out_valid_d     = 1'b1;
          out_d.kind      = KIND_ECHO;
          out_d.status    = STAT_OK;
          out_d.count     = '0;
          if (erase_q) begin
            // Backspace, space, backspace
            out_d.out_char = (ecnt_q == 2'd1) ? CH_SP : CH_BS;
            out_d.last     = (ecnt_q == 2'd2);
            ecnt_d         = ecnt_q + 2'd1;
            if (ecnt_q == 2'd2) begin
              state_d = S_IDLE;
            end
          end else begin
            out_d.out_char = char_q;
            out_d.last     = !drop_q;
            state_d        = drop_q ? S_STATUS : S_IDLE;
          end
        end
      end

      S_STATUS: begin
        if (can_emit) begin
          out_valid_d    = 1'b1;
          out_d.kind     = KIND_STATUS;
          out_d.out_char = '0;
          out_d.status   = status_q;
          out_d.count    = '0;
          out_d.last     = 1'b1;
          state_d        = S_IDLE;
        end
      end

      S_SCAN_RD: begin
        if (idx_q >= fill_q) begin
          // No line end in the store
          status_d = STAT_BLOCK;
          state_d  = S_STATUS;
        end else begin
          mem_re  = 1'b1;
          state_d = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        if ((rd_data_q == CH_LF) || (rd_data_q == CH_CR)) begin
          cons_d = idx_inc;
          take_d = (n_q < 7'(idx_inc)) ? CNT_W'(n_q) : idx_inc;
          idx_d  = '0;
          if (n_q == '0) begin
            // Discard the line, report an empty transfer
            head_d   = wrap_add(head_q, idx_inc);
            fill_d   = fill_q - idx_inc;
            status_d = STAT_OK;
            state_d  = S_STATUS;
          end else begin
            state_d = S_DATA_RD;
          end
        end else begin
          idx_d   = idx_inc;
          state_d = S_SCAN_RD;
        end
      end

      S_DATA_RD: begin
        mem_re  = 1'b1;
        state_d = S_DATA_OUT;
      end

      S_DATA_OUT: begin
        if (can_emit) begin
          out_valid_d    = 1'b1;
          out_d.kind     = KIND_DATA;
          out_d.out_char = rd_data_q;
          out_d.status   = STAT_OK;
          out_d.count    = 7'(take_q);
          out_d.last     = (idx_inc == take_q);
          if (idx_inc == take_q) begin
            // Drop the consumed bytes from the front of the ring
            head_d  = wrap_add(head_q, cons_q);
            fill_d  = fill_q - cons_q;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_inc;
            state_d = S_DATA_RD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      echo_q      <= 1'b1;
      canon_q     <= 1'b1;
      out_valid_q <= 1'b0;
      erase_q     <= 1'b0;
      drop_q      <= 1'b0;
      ecnt_q      <= '0;
      status_q    <= STAT_OK;
      n_q         <= '0;
      idx_q       <= '0;
      take_q      <= '0;
      cons_q      <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      erase_q     <= erase_d;
      drop_q      <= drop_d;
      ecnt_q      <= ecnt_d;
      status_q    <= status_d;
      n_q         <= n_d;
      idx_q       <= idx_d;
      take_q      <= take_d;
      cons_q      <= cons_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_ECHO:  echo_q  <= cfg_wdata_i;
          CFG_CANON: canon_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    char_q <= char_d;
  end

  // Line store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_data_i.key_char;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  `TLD_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= CNT_W'(BUF_DEPTH), "fill level beyond depth")
  `TLD_ASSERT_NXT(a_key_store,
      accept && (in_data_i.command == CMD_KEY) && !is_erase && (fill_q < CNT_W'(BUF_DEPTH)),
      fill_q == $past(fill_q) + CNT_W'(1), "stored keystroke did not advance fill level")
  `TLD_ASSERT_NXT(a_raw_zero,
      accept && (in_data_i.command == CMD_READ) && !canon_q && (in_data_i.read_count == '0),
      (state_q == S_STATUS) && (status_q == STAT_ZERO), "zero raw read not flagged")
  `TLD_ASSERT_IMP(a_data_idx, state_q == S_DATA_OUT, idx_q < take_q, "data index past take count")

endmodule
